>>> sv/lvd_pkg.sv
// Shared types and constants for the Levinson-Durbin coefficient block.
package lvd_pkg;

  // Width of the order field carried from front to back (orders up to 127)
  localparam int ORDER_W = 7;
  // Divider: |num| * 128 over a 31-bit energy
  localparam int DIVIDEND_W = 71;
  localparam int DIVISOR_W = 31;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               final_req;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic [5:0]         position;
    logic               end_of_set;
    logic               singular;
  } out_t;

  // Solve job handed from the front to the back
  typedef struct packed {
    logic               valid;
    logic [ORDER_W-1:0] order;
  } job_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_LOAD0,
    B_MSTART,
    B_MBASE,
    B_DOT_RD,
    B_DOT_MUL,
    B_DOT_ACC,
    B_DIV_START,
    B_DIV_WAIT,
    B_UPD_RD,
    B_UPD_MUL,
    B_UPD_WR,
    B_TAIL,
    B_EN_FACT,
    B_EN_MUL,
    B_EN_SHIFT,
    B_OUT_RD,
    B_OUT_EMIT
  } back_state_t;

endpackage

>>> sv/lvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lvd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lvd_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lvd_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [lvd_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              done,
  output logic [lvd_pkg::DIVIDEND_W-1:0]    quotient
);

  logic                               running;
  logic [lvd_pkg::DIV_CNT_W-1:0]      count;
  logic [lvd_pkg::DIVIDEND_W-1:0]     dvd;
  logic [lvd_pkg::DIVISOR_W-1:0]      dsr;
  logic [lvd_pkg::DIVISOR_W-1:0]      rem;
  logic [lvd_pkg::DIVISOR_W:0]        trial;
  logic                               qbit;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, dvd[lvd_pkg::DIVIDEND_W-1]};
    qbit  = (trial >= {1'b0, dsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= lvd_pkg::DIV_CNT_W'(lvd_pkg::DIVIDEND_W - 1);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (running) begin
      dvd      <= {dvd[lvd_pkg::DIVIDEND_W-2:0], 1'b0};
      rem      <= qbit ? lvd_pkg::DIVISOR_W'(trial - {1'b0, dsr})
                       : trial[lvd_pkg::DIVISOR_W-1:0];
      quotient <= {quotient[lvd_pkg::DIVIDEND_W-2:0], qbit};
    end
  end

endmodule

>>> sv/lvd_front.sv
// Front end: takes sample beats, stores them, queues a solve job on the final beat of a set of two or more.
module lvd_front #(
  parameter int MAX_ORDER = 32,
  localparam int CDEPTH = MAX_ORDER + 1,
  localparam int CAW = $clog2(CDEPTH),
  localparam int CNTW = $clog2(MAX_ORDER + 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lvd_pkg::in_t        item,
  output logic                busy,
  input  logic                back_busy,
  output logic                corr_we,
  output logic [CAW-1:0]      corr_waddr,
  output logic [31:0]         corr_wdata,
  output lvd_pkg::job_t       job,
  input  logic                job_pop
);

  logic [CNTW-1:0]                 load_count;
  logic                            accept;
  logic [lvd_pkg::ORDER_W-1:0]     order_next;

  // hold off while a job waits or the back end is solving
  assign busy   = job.valid | back_busy;
  assign accept = start & ~busy;

  assign corr_we    = accept && (load_count < CNTW'(CDEPTH));
  assign corr_waddr = load_count[CAW-1:0];
  assign corr_wdata = item.sample;

  // order of the set: stored count less one, capped by the store depth
  assign order_next = (load_count < CNTW'(CDEPTH)) ? lvd_pkg::ORDER_W'(load_count)
                                                   : lvd_pkg::ORDER_W'(MAX_ORDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      job.valid  <= 1'b0;
    end else begin
      if (job_pop) begin
        job.valid <= 1'b0;
      end
      if (accept) begin
        if (item.final_req) begin
          load_count <= '0;
          job.order  <= order_next;
          if (order_next != '0) begin
            job.valid <= 1'b1;
          end
        end else if (load_count < CNTW'(CDEPTH)) begin
          load_count <= load_count + 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/lvd_back.sv
// Back end: recursion sequencer with shared multiplier, divider and coefficient banks.
module lvd_back #(
  parameter int MAX_ORDER = 32,
  localparam int CAW = $clog2(MAX_ORDER + 1),
  localparam int KAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  lvd_pkg::job_t       job,
  output logic                job_pop,
  output logic                busy,
  output logic [CAW-1:0]      corr_raddr,
  input  logic [31:0]         corr_rdata,
  output logic                strobe,
  output lvd_pkg::out_t       result
);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  lvd_pkg::back_state_t state, state_next;

  logic [CAW-1:0]      p, m, i, o;
  logic                bank;
  logic                singular;
  logic signed [63:0]  num;
  logic [30:0]         err;
  logic [30:0]         factor;
  logic signed [31:0]  k;
  logic signed [31:0]  a_hold;
  logic signed [63:0]  prod;
  logic signed [31:0]  mul_a, mul_b;

  logic [KAW-1:0]      ka_addr, kb_addr, wr_addr;
  logic                wr_en;
  logic [31:0]         wr_data;
  logic [31:0]         rd_b0a, rd_b0b, rd_b1a, rd_b1b;
  logic signed [31:0]  rd_a, rd_b;

  logic                div_start, div_done;
  logic [lvd_pkg::DIVIDEND_W-1:0] div_q;
  logic [63:0]         num_mag;

  logic signed [63:0]  num_base, num_sum, num_acc;
  logic signed [31:0]  k_div, k_zero;
  logic [32:0]         q33;
  logic signed [63:0]  prod_adj;
  logic signed [34:0]  upd_sum;
  logic signed [31:0]  upd_val;
  logic signed [32:0]  k_adj;
  logic signed [31:0]  k_div128;
  logic [33:0]         ksq;
  logic                last_m;

  // coefficient banks: ping-pong, each bank kept twice for two read ports
  lvd_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_b0a (
    .clk, .we(wr_en & bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(ka_addr), .rdata(rd_b0a));
  lvd_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_b0b (
    .clk, .we(wr_en & bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(kb_addr), .rdata(rd_b0b));
  lvd_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_b1a (
    .clk, .we(wr_en & ~bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(ka_addr), .rdata(rd_b1a));
  lvd_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_b1b (
    .clk, .we(wr_en & ~bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(kb_addr), .rdata(rd_b1b));

  assign rd_a = bank ? rd_b1a : rd_b0a;
  assign rd_b = bank ? rd_b1b : rd_b0b;

  // reflection divider: |num|*128 / err
  assign num_mag = num[63] ? 64'(-num) : 64'(num);

  lvd_div u_div (
    .clk, .rst, .start(div_start),
    .dividend({num_mag, 7'b0}), .divisor(err),
    .done(div_done), .quotient(div_q));

  // arithmetic helpers
  always_comb begin
    num_base = 64'(signed'(corr_rdata)) <<< 23;
    num_sum  = num + prod;
    if (num[63] == prod[63] && num_sum[63] != num[63])
      num_acc = num[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    else
      num_acc = num_sum;

    // reflection term from the quotient, saturated
    q33 = div_q[32:0];
    if (div_q[lvd_pkg::DIVIDEND_W-1:7] > 64'(1 << 24))
      k_div = num[63] ? S32_MAX : S32_MIN;
    else if (!num[63])
      k_div = (q33 > 33'h080000000) ? S32_MIN : 32'(-q33);
    else
      k_div = (q33 > 33'h07FFFFFFF) ? S32_MAX : q33[31:0];

    // zero energy: opposite sign of num
    if (num > 0)      k_zero = S32_MIN;
    else if (num < 0) k_zero = S32_MAX;
    else              k_zero = '0;

    // a(i) + k*a(m-1-i)/2^30, truncated toward zero
    prod_adj = prod + (prod[63] ? 64'sd1073741823 : 64'sd0);
    upd_sum  = 35'(a_hold) + 35'(prod_adj >>> 30);
    if (upd_sum > 35'sd2147483647)       upd_val = S32_MAX;
    else if (upd_sum < -35'sd2147483648) upd_val = S32_MIN;
    else                                 upd_val = upd_sum[31:0];

    k_adj    = 33'(k) + (k[31] ? 33'sd127 : 33'sd0);
    k_div128 = 32'(k_adj >>> 7);

    ksq    = prod[63:30];
    last_m = (m + 1'b1 == p);
  end

  // shared multiplier, product registered for the next state
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= lvd_pkg::B_IDLE;
    else     state <= state_next;
  end

  // next state and control
  always_comb begin
    state_next = state;
    corr_raddr = '0;
    ka_addr    = '0;
    kb_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    job_pop    = 1'b0;
    case (state)
      lvd_pkg::B_IDLE: begin
        if (job.valid) begin
          job_pop    = 1'b1;
          state_next = lvd_pkg::B_LOAD0;
        end
      end
      lvd_pkg::B_LOAD0: state_next = lvd_pkg::B_MSTART;
      lvd_pkg::B_MSTART: begin
        corr_raddr = m + 1'b1;
        state_next = lvd_pkg::B_MBASE;
      end
      lvd_pkg::B_MBASE: begin
        state_next = (m == '0) ? lvd_pkg::B_DIV_START : lvd_pkg::B_DOT_RD;
      end
      lvd_pkg::B_DOT_RD: begin
        ka_addr    = KAW'(i);
        corr_raddr = m - i;
        state_next = lvd_pkg::B_DOT_MUL;
      end
      lvd_pkg::B_DOT_MUL: begin
        mul_a      = rd_a;
        mul_b      = corr_rdata;
        state_next = lvd_pkg::B_DOT_ACC;
      end
      lvd_pkg::B_DOT_ACC: begin
        state_next = (i + 1'b1 == m) ? lvd_pkg::B_DIV_START : lvd_pkg::B_DOT_RD;
      end
      lvd_pkg::B_DIV_START: begin
        if (err == '0) begin
          state_next = (m == '0) ? lvd_pkg::B_TAIL : lvd_pkg::B_UPD_RD;
        end else begin
          div_start  = 1'b1;
          state_next = lvd_pkg::B_DIV_WAIT;
        end
      end
      lvd_pkg::B_DIV_WAIT: begin
        if (div_done)
          state_next = (m == '0) ? lvd_pkg::B_TAIL : lvd_pkg::B_UPD_RD;
      end
      lvd_pkg::B_UPD_RD: begin
        ka_addr    = KAW'(i);
        kb_addr    = KAW'(m - i - 1'b1);
        state_next = lvd_pkg::B_UPD_MUL;
      end
      lvd_pkg::B_UPD_MUL: begin
        mul_a      = k;
        mul_b      = rd_b;
        state_next = lvd_pkg::B_UPD_WR;
      end
      lvd_pkg::B_UPD_WR: begin
        wr_en      = 1'b1;
        wr_addr    = KAW'(i);
        wr_data    = upd_val;
        state_next = (i + 1'b1 == m) ? lvd_pkg::B_TAIL : lvd_pkg::B_UPD_RD;
      end
      lvd_pkg::B_TAIL: begin
        wr_en      = 1'b1;
        wr_addr    = KAW'(m);
        wr_data    = k_div128;
        mul_a      = k;
        mul_b      = k;
        state_next = lvd_pkg::B_EN_FACT;
      end
      lvd_pkg::B_EN_FACT: begin
        if (ksq >= 34'(1 << 30) || err == '0)
          state_next = last_m ? lvd_pkg::B_OUT_RD : lvd_pkg::B_MSTART;
        else
          state_next = lvd_pkg::B_EN_MUL;
      end
      lvd_pkg::B_EN_MUL: begin
        mul_a      = {1'b0, err};
        mul_b      = {1'b0, factor};
        state_next = lvd_pkg::B_EN_SHIFT;
      end
      lvd_pkg::B_EN_SHIFT: begin
        state_next = last_m ? lvd_pkg::B_OUT_RD : lvd_pkg::B_MSTART;
      end
      lvd_pkg::B_OUT_RD: begin
        ka_addr    = KAW'(o);
        state_next = lvd_pkg::B_OUT_EMIT;
      end
      lvd_pkg::B_OUT_EMIT: begin
        state_next = (o + 1'b1 == p) ? lvd_pkg::B_IDLE : lvd_pkg::B_OUT_RD;
      end
      default: state_next = lvd_pkg::B_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      lvd_pkg::B_IDLE: begin
        if (job.valid) p <= CAW'(job.order);
      end
      lvd_pkg::B_LOAD0: begin
        err      <= ($signed(corr_rdata) > 0) ? corr_rdata[30:0] : '0;
        m        <= '0;
        singular <= 1'b0;
        bank     <= 1'b0;
      end
      lvd_pkg::B_MBASE: begin
        num <= num_base;
        i   <= '0;
      end
      lvd_pkg::B_DOT_ACC: begin
        num <= num_acc;
        i   <= i + 1'b1;
      end
      lvd_pkg::B_DIV_START: begin
        i <= '0;
        if (err == '0) begin
          singular <= 1'b1;
          k        <= k_zero;
        end
      end
      lvd_pkg::B_DIV_WAIT: begin
        if (div_done) k <= k_div;
      end
      lvd_pkg::B_UPD_MUL: a_hold <= rd_a;
      lvd_pkg::B_UPD_WR:  i <= i + 1'b1;
      lvd_pkg::B_EN_FACT: begin
        if (ksq >= 34'(1 << 30) || err == '0) begin
          err  <= '0;
          bank <= ~bank;
          m    <= m + 1'b1;
          o    <= '0;
        end else begin
          factor <= 31'(1 << 30) - {1'b0, ksq[29:0]};
        end
      end
      lvd_pkg::B_EN_SHIFT: begin
        err  <= prod[60:30];
        bank <= ~bank;
        m    <= m + 1'b1;
        o    <= '0;
      end
      lvd_pkg::B_OUT_EMIT: o <= o + 1'b1;
      default: ;
    endcase
  end

  // result beat
  assign busy                = (state != lvd_pkg::B_IDLE);
  assign strobe              = (state == lvd_pkg::B_OUT_EMIT);
  assign result.coefficient  = rd_a;
  assign result.position     = 6'(o);
  assign result.end_of_set   = (o + 1'b1 == p);
  assign result.singular     = singular;

endmodule

>>> sv/levinson_durbin_ar_coefficients.sv
// Each order step waits on the reflection divide (skipped at zero energy) and steps each term
// through read, multiply and accumulate or write on each pass through the shared multiplier.
// One sample beat per cycle while loading and busy is low; each result is read, then emitted.
// busy stays high from the final beat until the last result; the receiver cannot stall.
// Reset (rst, synchronous): clears the sample count, pending job and sequencer state.
module levinson_durbin_ar_coefficients #(
  parameter int MAX_ORDER = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lvd_pkg::in_t   item,
  output logic           strobe,
  output lvd_pkg::out_t  result
);

  localparam int CAW = $clog2(MAX_ORDER + 1);

  logic               back_busy;
  logic               corr_we;
  logic [CAW-1:0]     corr_waddr, corr_raddr;
  logic [31:0]        corr_wdata, corr_rdata;
  lvd_pkg::job_t      job;
  logic               job_pop;

  lvd_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk, .rst, .start, .item, .busy, .back_busy,
    .corr_we, .corr_waddr, .corr_wdata, .job, .job_pop);

  // autocorrelation store
  lvd_ram #(.WIDTH(32), .DEPTH(MAX_ORDER + 1)) u_corr (
    .clk, .we(corr_we), .waddr(corr_waddr), .wdata(corr_wdata),
    .raddr(corr_raddr), .rdata(corr_rdata));

  lvd_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk, .rst, .job, .job_pop, .busy(back_busy),
    .corr_raddr, .corr_rdata, .strobe, .result);

  // samples are never written under a running solve
  a_no_write_while_solving: assert property (@(posedge clk) disable iff (rst)
    corr_we |-> !back_busy) else $error("sample write during solve");

  // result beats never come back to back
  a_strobe_spacing: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("back-to-back result beats");

  // the last result of a set frees the block
  a_free_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.end_of_set) |=> !busy) else $error("busy after last result");

  // a pending job is taken by an idle back end
  a_job_taken: assert property (@(posedge clk) disable iff (rst)
    (job.valid && !back_busy) |=> back_busy) else $error("pending job not taken");

endmodule

>>> sim/levinson_durbin_ar_coefficients_tb.sv
// Testbench for the Levinson-Durbin AR coefficient block: directed table, overlong and full-order sets, random sets.
`timescale 1ns / 100ps

module levinson_durbin_ar_coefficients_tb;

  localparam int ORDER_MAX = 32;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint S64_MAX = 64'sh7fffffffffffffff;
  localparam longint S64_MIN = 64'sh8000000000000000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  lvd_pkg::in_t   item = '0;
  logic           strobe;
  lvd_pkg::out_t  result;

  levinson_durbin_ar_coefficients #(.MAX_ORDER(ORDER_MAX)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .strobe(strobe), .result(result)
  );

  always #5 clk = ~clk;

  // Predictor state
  int             corr_mem [ORDER_MAX+1];
  int             coef_mem [ORDER_MAX];
  int             coef_tmp [ORDER_MAX];
  int             corr_cnt = 0;
  bit             sing_flag;
  lvd_pkg::out_t  coef_queue [$];
  int             fail_cnt = 0;
  bit             quiet_end = 1'b0;

  function automatic longint add_sat64(longint x, longint y);
    if (y > 0 && x > S64_MAX - y) return S64_MAX;
    if (y < 0 && x < S64_MIN - y) return S64_MIN;
    return x + y;
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Reflection term in Q1.30; zero energy saturates and flags the set
  function automatic int reflection(longint num, longint err);
    longint q, rem, kk;
    if (err <= 0) begin
      sing_flag = 1'b1;
      if (num > 0) return 32'sh80000000;
      if (num < 0) return 32'sh7fffffff;
      return 0;
    end
    q = num / err;
    rem = num % err;
    if (q > (64'sd1 << 24)) return 32'sh80000000;
    if (q < -(64'sd1 << 24)) return 32'sh7fffffff;
    kk = q * 128 + (rem * 128) / err;
    return clip32(-kk);
  endfunction

  task automatic run_recursion(int p);
    longint err, num, ksq, factor;
    int kr;
    err = corr_mem[0] > 0 ? longint'(corr_mem[0]) : 0;
    sing_flag = 1'b0;
    for (int m = 0; m < p; m++) begin
      num = longint'(corr_mem[m+1]) * 8388608;
      for (int i = 0; i < m; i++)
        num = add_sat64(num, longint'(coef_mem[i]) * corr_mem[m-i]);
      kr = reflection(num, err);
      for (int i = 0; i < m; i++)
        coef_tmp[i] = clip32(longint'(coef_mem[i]) +
                             (longint'(kr) * coef_mem[m-1-i]) / ONE_Q30);
      coef_tmp[m] = kr / 128;
      for (int i = 0; i <= m; i++) coef_mem[i] = coef_tmp[i];
      ksq = (longint'(kr) * kr) / ONE_Q30;
      factor = ONE_Q30 - ksq;
      if (factor <= 0 || err <= 0) err = 0;
      else err = (err * factor) / ONE_Q30;
    end
  endtask

  // Predict the coefficients caused by one accepted beat
  task automatic predict_beat(lvd_pkg::in_t b);
    int p;
    lvd_pkg::out_t o;
    if (corr_cnt < ORDER_MAX + 1) begin
      corr_mem[corr_cnt] = b.sample;
      corr_cnt++;
    end
    if (!b.final_req) return;
    p = corr_cnt - 1;
    corr_cnt = 0;
    if (p == 0) return;
    run_recursion(p);
    for (int k = 0; k < p; k++) begin
      o.coefficient = coef_mem[k];
      o.position = 6'(k);
      o.end_of_set = (k == p - 1);
      o.singular = sing_flag;
      coef_queue.push_back(o);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (coef_queue.size() == 0) begin
        $error("unexpected result: coefficient %0d position %0d",
               result.coefficient, result.position);
        fail_cnt++;
      end else begin
        lvd_pkg::out_t e;
        e = coef_queue.pop_front();
        if (result.coefficient !== e.coefficient) begin
          $error("coefficient: expected %0d, got %0d", e.coefficient, result.coefficient);
          fail_cnt++;
        end
        if (result.position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, result.position);
          fail_cnt++;
        end
        if (result.end_of_set !== e.end_of_set) begin
          $error("end_of_set: expected %0d, got %0d", e.end_of_set, result.end_of_set);
          fail_cnt++;
        end
        if (result.singular !== e.singular) begin
          $error("singular: expected %0d, got %0d", e.singular, result.singular);
          fail_cnt++;
        end
      end
    end
  end

  // Send one beat, with an optional random gap before it; start stays high
  // between back-to-back beats and is dropped only for a gap or at the end
  task automatic send_beat(logic signed [31:0] s, logic f);
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    item <= '{sample: s, final_req: f};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat('{sample: s, final_req: f});
    @(negedge clk);
  endtask

  // Directed table: sample, final flag
  typedef struct {
    logic signed [31:0] s;
    logic               f;
  } row_t;

  row_t dir_rows [] = '{
    '{32'sd1000, 1'b1},                       // single value, no output
    '{32'sd1000, 1'b0}, '{32'sd500, 1'b1},    // order 1
    '{32'sd0, 1'b0}, '{32'sd100, 1'b1},       // zero energy: singular
    '{-32'sd5, 1'b0}, '{32'sd0, 1'b1},        // negative r0, zero num
    '{32'sh7fffffff, 1'b0}, '{32'sh80000000, 1'b0}, '{32'sh7fffffff, 1'b1},
    '{32'sd1, 1'b0}, '{32'sh7fffffff, 1'b1},  // huge ratio saturates
    '{32'sd4096, 1'b0}, '{32'sd2048, 1'b0}, '{32'sd1024, 1'b0},
    '{32'sd512, 1'b0}, '{32'sd256, 1'b1},
    '{32'sh80000000, 1'b0}, '{32'sd7, 1'b1}
  };

  initial begin
    int n_items;
    int len, r0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].s, dir_rows[i].f);

    // Overlong set: 40 values, extra ones dropped
    for (int i = 0; i < 40; i++)
      send_beat(i == 0 ? 32'sd1000000 : 32'($urandom_range(0, 2000)) - 1000, i == 39);
    // Full order 32 with a correlation that halves at each lag and wraps back to 2^30 after 30 lags
    for (int i = 0; i <= 32; i++) send_beat(32'sd1 << (30 - (i % 30)), i == 32);

    // Random sets: mostly well formed, some noise
    n_items = 0;
    while (n_items < 290) begin
      if (n_items > 240) quiet_end = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 8);
      r0 = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, 32'h3fffffff);
      for (int i = 0; i < len; i++) begin
        logic signed [31:0] s;
        case ($urandom_range(0, 5))
          0: s = $urandom;
          1: s = -(r0 / 2) + $urandom_range(0, r0 > 0 ? r0 : 1);
          default: s = r0 / (i + 1);
        endcase
        send_beat(i == 0 ? r0 : s, i == len - 1);
        n_items++;
      end
    end
    start <= 1'b0;

    // Drain
    while (coef_queue.size() != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && coef_queue.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
sv/lvd_pkg.sv
sv/lvd_ram.sv
sv/lvd_div.sv
sv/lvd_front.sv
sv/lvd_back.sv
sv/levinson_durbin_ar_coefficients.sv
sim/levinson_durbin_ar_coefficients_tb.sv
